// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned OCC_W        = 7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compare against the new value, then hold,
// take the new value, or take a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                                   clk,
  input  wire spq_pkg::ctrl_t                   ctrl,
  input  wire logic                             live,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] new_value,
  input  wire logic                             prev_le,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] prev_entry,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] next_entry,
  output logic                                  le,
  output logic signed [spq_pkg::VALUE_W-1:0]    entry
);

  logic signed [spq_pkg::VALUE_W-1:0] entry_r;
  logic signed [spq_pkg::VALUE_W-1:0] entry_nxt;
  logic                               gt;

  assign gt    = live && (entry_r > new_value);
  assign le    = live && !gt;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (live && !gt) begin
        entry_nxt = entry_r;
      end else if (prev_le) begin
        entry_nxt = new_value;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-priority queue held in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// For every item (insert or remove), all cells compare against the new value
// and shift in parallel at the accepting edge, so an item may be started
// every cycle and busy stays low. The result appears on the out_ ports in the
// cycle after the start transfer, marked by out_valid for exactly one cycle;
// the receiver cannot stall, so it must take every result then.
// Equal values leave in arrival order. Occupancy reports the count modulo
// 128.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_kind,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] in_value,
  output logic                                    out_valid,
  output logic [1:0]                              out_status,
  output logic signed [spq_pkg::VALUE_W-1:0]      out_removed_value,
  output logic [spq_pkg::OCC_W-1:0]               out_occupancy
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept, full, empty;
  spq_pkg::ctrl_t   ctrl;
  spq_pkg::status_t status;

  logic                               out_valid_r;
  spq_pkg::status_t                   out_status_r;
  logic signed [spq_pkg::VALUE_W-1:0] out_removed_r;
  logic [spq_pkg::OCC_W-1:0]          out_occ_r;

  logic signed [spq_pkg::VALUE_W-1:0] entry [CAPACITY];
  logic                               le    [CAPACITY];
  logic                               live  [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CAP_CNT);
  assign empty  = (count_r == '0);

  always_comb begin
    ctrl      = '0;
    status    = spq_pkg::ST_OK;
    count_nxt = count_r;
    if (accept) begin
      case (spq_pkg::kind_t'(in_kind))
        spq_pkg::KIND_INSERT: begin
          if (full) begin
            status = spq_pkg::ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        spq_pkg::KIND_REMOVE: begin
          if (empty) begin
            status = spq_pkg::ST_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
      logic                               prev_le_w;
      logic signed [spq_pkg::VALUE_W-1:0] prev_w, next_w;

      assign live[gi] = (IDX < count_r);

      if (gi == 0) begin : g_head
        assign prev_le_w = 1'b1;
        assign prev_w    = in_value;
      end else begin : g_body
        assign prev_le_w = le[gi-1];
        assign prev_w    = entry[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign next_w = in_value;
      end else begin : g_mid
        assign next_w = entry[gi+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .live       (live[gi]),
        .new_value  (in_value),
        .prev_le    (prev_le_w),
        .prev_entry (prev_w),
        .next_entry (next_w),
        .le         (le[gi]),
        .entry      (entry[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= ctrl.rem ? entry[0] : '0;
      out_occ_r     <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_occupancy     = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("count above capacity");

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("result strobe missing after start");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status == spq_pkg::ST_FULL) |=> (count_r == CAP_CNT))
    else $error("full refusal changed count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == spq_pkg::ST_EMPTY)
      |-> (out_occupancy == '0 && out_removed_value == '0))
    else $error("empty refusal with nonzero result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count moved without a transfer");

endmodule

`default_nettype wire

// ===== tb/sv/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking testbench for the sorted minimum-priority queue.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own ascending copy of the queue and predicts status,
// removed value and occupancy for every accepted command. A directed pass hits
// the value extremes, ties and the empty case. Random phases then swing the
// queue from empty to full and back, with and without gaps between commands.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QCAP       = spq_pkg::CAPACITY_DEF;
  localparam int unsigned IDLE_LIMIT = 200;

  typedef struct {
    spq_pkg::status_t                     status;
    logic signed [spq_pkg::VALUE_W-1:0]   removed;
    logic [spq_pkg::OCC_W-1:0]            occ;
  } spq_result_t;

  class spq_scoreboard;
    logic signed [spq_pkg::VALUE_W-1:0] held[$];
    spq_result_t                        pending_results[$];
    int unsigned errors;
    int unsigned n_ins, n_rem, n_full, n_empty, peak_occ;

    function void note_item(spq_pkg::kind_t kind,
                            logic signed [spq_pkg::VALUE_W-1:0] value);
      spq_result_t r;
      int          pos;
      r.status  = spq_pkg::ST_OK;
      r.removed = '0;
      if (kind == spq_pkg::KIND_INSERT) begin
        n_ins++;
        if (held.size() >= QCAP) begin
          r.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          pos = held.size();
          while (pos > 0 && held[pos-1] > value) pos--;
          held.insert(pos, value);
        end
      end else begin
        n_rem++;
        if (held.size() == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.removed = held.pop_front();
        end
      end
      if (held.size() > peak_occ) peak_occ = held.size();
      r.occ = spq_pkg::OCC_W'(held.size());
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status,
                               logic signed [spq_pkg::VALUE_W-1:0] removed,
                               logic [spq_pkg::OCC_W-1:0] occ);
      spq_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d removed %0d occupancy %0d",
                 $time, status, removed, occ);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (removed !== e.removed) begin
        $display("%0t: removed_value expected %0d actual %0d", $time, e.removed, removed);
        errors++;
      end
      if (occ !== e.occ) begin
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occ);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n    = 1'b0;
  logic                               start    = 1'b0;
  logic                               in_kind  = spq_pkg::KIND_INSERT;
  logic signed [spq_pkg::VALUE_W-1:0] in_value = '0;
  logic                               busy;
  logic                               out_valid;
  logic [1:0]                         out_status;
  logic signed [spq_pkg::VALUE_W-1:0] out_removed_value;
  logic [spq_pkg::OCC_W-1:0]          out_occupancy;

  spq_scoreboard sb = new();
  int unsigned   idle_cycles = 0;

  sorted_priority_queue #(.CAPACITY(QCAP)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_occupancy    (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input noted before result so a same-edge result still finds its entry
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_item(spq_pkg::kind_t'(in_kind), in_value);
      if (out_valid) sb.check_result(out_status, out_removed_value, out_occupancy);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("sorted_priority_queue regression: fail");
      $finish;
    end
  end

  task automatic send_item(spq_pkg::kind_t kind, logic signed [spq_pkg::VALUE_W-1:0] value,
                           int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6, 7: return spq_pkg::VALUE_W'(int'($urandom_range(0, 8)) - 4);
      8:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      9:       return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [spq_pkg::VALUE_W-1:0] seeds[10];
    int unsigned ins_pct[6];
    int unsigned gap;

    seeds   = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 0, 32'sh80000000, 32'sh7fffffff,
                32'sh55555555, 32'shaaaaaaaa};
    ins_pct = '{95, 50, 5, 95, 50, 5};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, extremes and ties, then drain past empty
    send_item(spq_pkg::KIND_REMOVE, 32'sh12345678, 0);
    foreach (seeds[i]) send_item(spq_pkg::KIND_INSERT, seeds[i], $urandom_range(0, 3));
    repeat (11) send_item(spq_pkg::KIND_REMOVE, $urandom, $urandom_range(0, 3));

    // random: fill to full, mix, drain to empty, twice
    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < 72; n++) begin
        gap = (p % 3 == 1) ? 0 : $urandom_range(0, 17);
        send_item(($urandom_range(0, 99) < ins_pct[p]) ? spq_pkg::KIND_INSERT
                                                       : spq_pkg::KIND_REMOVE,
                  pick_value(), gap);
      end
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d inserts and %0d removes, peak occupancy %0d of %0d",
             sb.n_ins, sb.n_rem, sb.peak_occ, QCAP);
    $display("refused %0d inserts when full and %0d removes when empty",
             sb.n_full, sb.n_empty);
    if (sb.errors == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
